// ===== rtl/humidity_temp_frame_checker_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the humidity and temperature frame checker
// Shared wrappers so every check uses the same clock and report form.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_CHECKER_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_CHECKER_ASSERT_SVH

// Clocked check that is switched off while reset is high.
`define HTFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds while reset is high.
`define HTFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/htfc_pkg.sv =====
// ----------------------------------------------------------------------------
// htfc_pkg
// Types, codes and helpers shared by the frame checker modules.
// ----------------------------------------------------------------------------
package htfc_pkg;

  // Position of a byte inside a six-byte response frame.
  typedef logic [2:0] byte_pos_t;
  localparam byte_pos_t POS_TEMP_MSB = 3'd0;
  localparam byte_pos_t POS_TEMP_LSB = 3'd1;
  localparam byte_pos_t POS_TEMP_CRC = 3'd2;
  localparam byte_pos_t POS_HUM_MSB  = 3'd3;
  localparam byte_pos_t POS_HUM_LSB  = 3'd4;
  localparam byte_pos_t POS_HUM_CRC  = 3'd5;

  // CRC-8, polynomial x^8 + x^5 + x^4 + 1, no reflection, no final XOR.
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_CRC_ERROR   = 2'd1,
    STATUS_RANGE_ERROR = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_TEMP_MIN = 1'b0,
    CFG_TEMP_MAX = 1'b1
  } cfg_index_t;

  // Signed value in hundredths of a unit.
  typedef logic signed [14:0] centi_t;

  localparam centi_t TEMP_MIN_RESET = -15'sd4000;
  localparam centi_t TEMP_MAX_RESET = 15'sd12500;

  // Conversion constants.
  localparam logic [14:0] TEMP_SCALE   = 15'd17500;
  localparam logic [13:0] HUM_SCALE    = 14'd12500;
  localparam logic [15:0] TEMP_OFFSET  = 16'd4500;
  localparam logic [13:0] HUM_OFFSET   = 14'd600;
  localparam logic [13:0] HUM_CLAMP_HI = 14'd10000;
  localparam logic [13:0] HUM_RAW_HI   = 14'd10600;

  // One finished frame handed from the byte front end to the converter.
  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_humidity;
    logic        crc_failed;
  } frame_t;

  // Runs one byte through the CRC, one bit per step.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/htfc_byte_if.sv =====
// ----------------------------------------------------------------------------
// htfc_byte_if
// Byte channel into the frame checker: one response byte per transfer.
// ----------------------------------------------------------------------------
interface htfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== rtl/htfc_result_if.sv =====
// ----------------------------------------------------------------------------
// htfc_result_if
// Result channel out of the frame checker: one decoded frame per transfer.
// ----------------------------------------------------------------------------
interface htfc_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [14:0] temp_centi;
  logic [13:0]        humidity_centi;
  logic [15:0]        raw_temp;
  logic [15:0]        raw_humidity;

  modport source (
    output valid, output status, output temp_centi, output humidity_centi,
    output raw_temp, output raw_humidity, input ready
  );
  modport sink (
    input valid, input status, input temp_centi, input humidity_centi,
    input raw_temp, input raw_humidity, output ready
  );
endinterface

// ===== rtl/htfc_front.sv =====
// ----------------------------------------------------------------------------
// htfc_front
// Byte front end: tracks the frame position, assembles the raw words and
// checks each word's CRC. Hands a finished frame to the queue.
// ----------------------------------------------------------------------------
module htfc_front
  import htfc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  htfc_byte_if.sink rx,
  output logic   push_valid,
  input  logic   push_ready,
  output frame_t push_frame
);

  byte_pos_t   byte_pos;
  logic [7:0]  running_crc;
  logic        crc_failed;
  logic [15:0] temp_word;
  logic [15:0] humidity_word;

  byte_pos_t   pos_eff;
  logic [7:0]  crc_eff;
  logic        failed_eff;
  logic        crc_bad;
  logic        accept;

  // A start flag or an impossible position begins a new frame with this byte.
  always_comb begin
    if (rx.frame_start || byte_pos > POS_HUM_CRC) begin
      pos_eff    = POS_TEMP_MSB;
      crc_eff    = CRC_INIT;
      failed_eff = 1'b0;
    end else begin
      pos_eff    = byte_pos;
      crc_eff    = running_crc;
      failed_eff = crc_failed;
    end
  end

  assign crc_bad = (crc_eff != rx.rx_byte);
  assign accept  = rx.valid && rx.ready;

  // The byte side stalls only when the queue is full.
  assign rx.ready   = push_ready;
  assign push_valid = rx.valid && (pos_eff == POS_HUM_CRC);

  always_comb begin
    push_frame.raw_temp     = temp_word;
    push_frame.raw_humidity = humidity_word;
    push_frame.crc_failed   = failed_eff || crc_bad;
  end

  // Frame control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= POS_TEMP_MSB;
      running_crc <= CRC_INIT;
      crc_failed  <= 1'b0;
    end else if (accept) begin
      case (pos_eff)
        POS_TEMP_MSB, POS_TEMP_LSB, POS_HUM_MSB, POS_HUM_LSB: begin
          running_crc <= crc8_update(crc_eff, rx.rx_byte);
          crc_failed  <= failed_eff;
          byte_pos    <= pos_eff + 3'd1;
        end
        POS_TEMP_CRC: begin
          running_crc <= CRC_INIT;
          crc_failed  <= failed_eff || crc_bad;
          byte_pos    <= pos_eff + 3'd1;
        end
        default: begin
          // Last byte of the frame: start over.
          running_crc <= CRC_INIT;
          crc_failed  <= 1'b0;
          byte_pos    <= POS_TEMP_MSB;
        end
      endcase
    end
  end

  // Raw word assembly.
  always_ff @(posedge clk) begin
    if (accept) begin
      case (pos_eff)
        POS_TEMP_MSB: temp_word     <= {rx.rx_byte, 8'h00};
        POS_TEMP_LSB: temp_word     <= {temp_word[15:8], rx.rx_byte};
        POS_HUM_MSB:  humidity_word <= {rx.rx_byte, 8'h00};
        POS_HUM_LSB:  humidity_word <= {humidity_word[15:8], rx.rx_byte};
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/htfc_queue.sv =====
// ----------------------------------------------------------------------------
// htfc_queue
// Small flop-based FIFO of finished frames between front end and converter.
// ----------------------------------------------------------------------------
module htfc_queue
  import htfc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  frame_t push_frame,
  output logic   pop_valid,
  input  logic   pop_ready,
  output frame_t pop_frame
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_frame  = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Frame storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

endmodule

// ===== rtl/htfc_back.sv =====
// ----------------------------------------------------------------------------
// htfc_back
// Converter: scales the raw words to centidegrees and centipercent, checks
// the temperature range and holds the result for the receiver.
// ----------------------------------------------------------------------------
module htfc_back
  import htfc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pop_valid,
  output logic   pop_ready,
  input  frame_t pop_frame,
  input  centi_t temp_min,
  input  centi_t temp_max,
  htfc_result_if.source result
);

  // floor(x / 65535) for x below 17501 * 65536: one estimate, one correction.
  function automatic logic [14:0] div_by_65535(input logic [30:0] x);
    logic [14:0] q0;
    logic [16:0] r0;
    q0 = x[30:16];
    r0 = {1'b0, x[15:0]} + {2'b00, q0};
    return q0 + {14'd0, (r0 >= 17'd65535)};
  endfunction

  // Stage 1: products.
  logic        s1_valid;
  frame_t      s1_frame;
  logic [30:0] s1_temp_prod;
  logic [29:0] s1_hum_prod;
  // Stage 2: quotients.
  logic        s2_valid;
  frame_t      s2_frame;
  logic [14:0] s2_temp_q;
  logic [13:0] s2_hum_q;

  logic s1_ready;
  logic s2_ready;
  logic out_ready;

  logic signed [15:0] temp_wide;
  centi_t             temp_val;
  logic [13:0]        hum_val;
  status_t            status_val;

  assign out_ready = !result.valid || result.ready;
  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign pop_ready = s1_ready;

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pop_valid) begin
      s1_frame     <= pop_frame;
      s1_temp_prod <= 31'(pop_frame.raw_temp) * 31'(TEMP_SCALE);
      s1_hum_prod  <= 30'(pop_frame.raw_humidity) * 30'(HUM_SCALE);
    end
  end

  // Divide-by-65535 stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_frame  <= s1_frame;
      s2_temp_q <= div_by_65535(s1_temp_prod);
      s2_hum_q  <= 14'(div_by_65535({1'b0, s1_hum_prod}));
    end
  end

  // Offsets, humidity clamp and status.
  always_comb begin
    temp_wide = signed'({1'b0, s2_temp_q}) - signed'(TEMP_OFFSET);
    temp_val  = temp_wide[14:0];
    if (s2_hum_q < HUM_OFFSET) begin
      hum_val = '0;
    end else if (s2_hum_q > HUM_RAW_HI) begin
      hum_val = HUM_CLAMP_HI;
    end else begin
      hum_val = s2_hum_q - HUM_OFFSET;
    end
    if (s2_frame.crc_failed) begin
      status_val = STATUS_CRC_ERROR;
      temp_val   = '0;
      hum_val    = '0;
    end else if (temp_val < temp_min || temp_val > temp_max) begin
      status_val = STATUS_RANGE_ERROR;
    end else begin
      status_val = STATUS_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_ready) begin
      result.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid) begin
      result.status         <= status_val;
      result.temp_centi     <= temp_val;
      result.humidity_centi <= hum_val;
      result.raw_temp       <= s2_frame.raw_temp;
      result.raw_humidity   <= s2_frame.raw_humidity;
    end
  end

endmodule

// ===== rtl/humidity_temp_frame_checker.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_frame_checker
// Checks and converts six-byte humidity and temperature sensor responses.
// ----------------------------------------------------------------------------
// Usage:
// - rx carries one response byte per transfer, in the order temperature MSB,
//   LSB, CRC, humidity MSB, LSB, CRC. frame_start marks a byte as the first
//   of a frame and drops any partial frame.
// - result carries one decoded frame per six bytes: status, converted
//   temperature and humidity, and both raw words.
// - cfg_we/cfg_index/cfg_data write the temperature limits; write them only
//   while no frame is in flight.
// - Throughput: one byte per cycle, sustained. The converter takes one frame
//   per cycle, so rx only stalls when the receiver holds off results.
// - Path to the result: the frame is queued at the transfer of the sixth
//   byte, then passes the multiply stage, the divide stage and the output
//   register, where the result is offered.
// - When the receiver stalls, the result is held, the converter stages and
//   the frame queue fill up, and rx.ready drops once the queue is full.
// - Reset clears the frame position, the CRC and all valid flags, and loads
//   the default limits -40.00 and 125.00 degrees.
// ----------------------------------------------------------------------------
module humidity_temp_frame_checker
  import htfc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  htfc_byte_if.sink  rx,
  htfc_result_if.source result,
  input  logic       cfg_we,
  input  cfg_index_t cfg_index,
  input  logic [14:0] cfg_data
);

  logic   push_valid;
  logic   push_ready;
  frame_t push_frame;
  logic   pop_valid;
  logic   pop_ready;
  frame_t pop_frame;
  centi_t temp_min;
  centi_t temp_max;

  // Temperature limit registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_min <= TEMP_MIN_RESET;
      temp_max <= TEMP_MAX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP_MIN: temp_min <= cfg_data;
        CFG_TEMP_MAX: temp_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  htfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame)
  );

  htfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_frame  (pop_frame)
  );

  htfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_frame (pop_frame),
    .temp_min  (temp_min),
    .temp_max  (temp_max),
    .result    (result)
  );

endmodule

// ===== rtl/htfc_checker.sv =====
// ----------------------------------------------------------------------------
// htfc_checker
// Port-level checks on the result channel of the frame checker.
// ----------------------------------------------------------------------------
`include "humidity_temp_frame_checker_assert.svh"

module htfc_checker
  import htfc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [1:0]         res_status,
  input logic signed [14:0] res_temp_centi,
  input logic [13:0]        res_humidity_centi
);

  // A result waiting for the receiver stays offered.
  `HTFC_ASSERT(a_result_held, res_valid && !res_ready |=> res_valid, "result dropped while stalled")

  // No result comes out of reset.
  `HTFC_ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> !res_valid, "result valid right after reset")

  // A CRC failure zeroes the converted values.
  `HTFC_ASSERT(a_crc_zero, res_valid && res_status == STATUS_CRC_ERROR |-> res_temp_centi == 15'sd0 && res_humidity_centi == 14'd0, "converted values not zero on CRC error")

  // Humidity is clamped to 100.00 percent.
  `HTFC_ASSERT(a_hum_clamp, res_valid |-> res_humidity_centi <= 14'd10000, "humidity above clamp")

  // Temperature stays at or above the sensor's floor of -45.00 and status is a defined code.
  `HTFC_ASSERT(a_temp_span, res_valid |-> res_temp_centi >= -15'sd4500 && res_status != 2'd3, "temperature or status out of span")

endmodule

bind humidity_temp_frame_checker htfc_checker u_htfc_checker (
  .clk                (clk),
  .rst                (rst),
  .res_valid          (result.valid),
  .res_ready          (result.ready),
  .res_status         (result.status),
  .res_temp_centi     (result.temp_centi),
  .res_humidity_centi (result.humidity_centi)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for humidity_temp_frame_checker
// Streams six-byte sensor responses, both clean and damaged, into the rx
// channel under random bursts and result back-pressure. A local decoder
// tracks the frame position, the CRC-8 and the temperature limits. It
// predicts every decoded frame, and each frame is checked field by field as
// it leaves the result channel.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import htfc_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    logic [7:0] value;
    logic       first;
  } rx_item_t;

  typedef struct {
    status_t     status;
    centi_t      temp;
    logic [13:0] humidity;
    logic [15:0] raw_temp;
    logic [15:0] raw_humidity;
  } frame_expect_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  cfg_index_t  cfg_index;
  logic [14:0] cfg_data;

  htfc_byte_if   rx ();
  htfc_result_if result ();

  humidity_temp_frame_checker u_dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bytes waiting to be sent and frames waiting to come out.
  rx_item_t      byte_queue[$];
  frame_expect_t expected_frames[$];

  // Local copy of the decoder state and limits.
  byte_pos_t   frame_pos;
  logic [7:0]  word_crc_acc;
  logic [15:0] temp_word;
  logic [15:0] hum_word;
  logic        frame_bad_crc;
  centi_t      temp_min;
  centi_t      temp_max;

  int fail_count = 0;
  int frames_checked = 0;
  int quiet_cycles = 0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One byte through CRC-8, shifting the data in bit by bit.
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] word_crc(input logic [15:0] w);
    return crc_feed(crc_feed(CRC_INIT, w[15:8]), w[7:0]);
  endfunction

  // Takes one accepted byte; returns 1 and fills the frame when it is the sixth.
  function automatic bit decode_byte(input logic [7:0] b, input logic first,
                                     output frame_expect_t frame);
    int t;
    int h;
    if (first || frame_pos > POS_HUM_CRC) begin
      frame_pos = POS_TEMP_MSB;
      word_crc_acc = CRC_INIT;
      frame_bad_crc = 1'b0;
    end
    case (frame_pos)
      POS_TEMP_MSB: begin
        temp_word = {b, 8'h00};
        word_crc_acc = crc_feed(word_crc_acc, b);
      end
      POS_TEMP_LSB: begin
        temp_word[7:0] = b;
        word_crc_acc = crc_feed(word_crc_acc, b);
      end
      POS_HUM_MSB: begin
        hum_word = {b, 8'h00};
        word_crc_acc = crc_feed(word_crc_acc, b);
      end
      POS_HUM_LSB: begin
        hum_word[7:0] = b;
        word_crc_acc = crc_feed(word_crc_acc, b);
      end
      default: begin
        if (word_crc_acc != b) begin
          frame_bad_crc = 1'b1;
        end
        word_crc_acc = CRC_INIT;
      end
    endcase
    if (frame_pos != POS_HUM_CRC) begin
      frame_pos = frame_pos + 3'd1;
      return 1'b0;
    end

    // Sixth byte: convert, check and start over.
    t = -4500 + int'((longint'(temp_word) * 17500) / 65535);
    h = -600 + int'((longint'(hum_word) * 12500) / 65535);
    if (h < 0) begin
      h = 0;
    end
    if (h > 10000) begin
      h = 10000;
    end
    if (frame_bad_crc) begin
      frame.status = STATUS_CRC_ERROR;
      t = 0;
      h = 0;
    end else if (t < temp_min || t > temp_max) begin
      frame.status = STATUS_RANGE_ERROR;
    end else begin
      frame.status = STATUS_OK;
    end
    frame.temp = t[14:0];
    frame.humidity = h[13:0];
    frame.raw_temp = temp_word;
    frame.raw_humidity = hum_word;
    frame_pos = POS_TEMP_MSB;
    word_crc_acc = CRC_INIT;
    frame_bad_crc = 1'b0;
    return 1'b1;
  endfunction

  // Sender: bursts of random length with random gaps in between.
  always @(posedge clk) begin : drive_rx
    rx_item_t      item;
    frame_expect_t frame;
    int            burst_left;
    int            gap_left;
    if (rst) begin
      rx.valid <= 1'b0;
      rx.rx_byte <= '0;
      rx.frame_start <= 1'b0;
      burst_left = 0;
      gap_left = 0;
      frame_pos = POS_TEMP_MSB;
      word_crc_acc = CRC_INIT;
      temp_word = '0;
      hum_word = '0;
      frame_bad_crc = 1'b0;
    end else begin
      if (rx.valid && rx.ready) begin
        if (decode_byte(rx.rx_byte, rx.frame_start, frame)) begin
          expected_frames.push_back(frame);
        end
      end
      if (!rx.valid || rx.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          rx.valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          item = byte_queue.pop_front();
          rx.valid <= 1'b1;
          rx.rx_byte <= item.value;
          rx.frame_start <= item.first;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          rx.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a random ready pattern, now and then a long hold-off.
  always @(posedge clk) begin : drive_ready
    logic [15:0] pattern;
    logic [5:0]  step;
    int          hold_left;
    int          hold_mark;
    if (rst) begin
      result.ready <= 1'b0;
      pattern = '1;
      step = '0;
      hold_left = 0;
      hold_mark = 30;
    end else begin
      if (hold_left == 0 && frames_checked == hold_mark) begin
        hold_left = LONG_HOLD;
        hold_mark = hold_mark + 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        if (step == '0) begin
          pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
        result.ready <= pattern[step[3:0]];
        step = step + 6'd1;
      end
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    fail_count++;
    $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
  endtask

  // Checker: every result transfer against the oldest expected frame.
  always @(posedge clk) begin : check_result
    frame_expect_t want;
    if (!rst && result.valid && result.ready) begin
      if (expected_frames.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, actual raw %h/%h", $time,
                 result.raw_temp, result.raw_humidity);
      end else begin
        want = expected_frames.pop_front();
        if (result.status !== want.status) begin
          report_field("status", want.status, result.status);
        end
        if (result.temp_centi !== want.temp) begin
          report_field("temp_centi", want.temp, result.temp_centi);
        end
        if (result.humidity_centi !== want.humidity) begin
          report_field("humidity_centi", want.humidity, result.humidity_centi);
        end
        if (result.raw_temp !== want.raw_temp) begin
          report_field("raw_temp", want.raw_temp, result.raw_temp);
        end
        if (result.raw_humidity !== want.raw_humidity) begin
          report_field("raw_humidity", want.raw_humidity, result.raw_humidity);
        end
      end
      frames_checked <= frames_checked + 1;
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin : watchdog
    if (rst || (rx.valid && rx.ready) || (result.valid && result.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] value, input logic first);
    rx_item_t item;
    item.value = value;
    item.first = first;
    byte_queue.push_back(item);
  endtask

  // Queues one frame; a damaged word gets a wrong CRC byte.
  task automatic push_frame(input logic [15:0] tw, input logic [15:0] hw,
                            input bit bad_temp, input bit bad_hum, input logic first);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = word_crc(tw);
    hc = word_crc(hw);
    if (bad_temp) begin
      tc = tc ^ 8'($urandom_range(1, 255));
    end
    if (bad_hum) begin
      hc = hc ^ 8'($urandom_range(1, 255));
    end
    push_byte(tw[15:8], first);
    push_byte(tw[7:0], 1'b0);
    push_byte(tc, 1'b0);
    push_byte(hw[15:8], 1'b0);
    push_byte(hw[7:0], 1'b0);
    push_byte(hc, 1'b0);
  endtask

  // Smallest raw word that converts to the given temperature.
  function automatic int raw_for_temp(input centi_t t);
    int k;
    k = t + 4500;
    return (k * 65535 + 17499) / 17500;
  endfunction

  // Raw temperature, often placed right at one of the limits.
  function automatic logic [15:0] pick_temp_word();
    int r;
    int d;
    d = $urandom_range(0, 2);
    case ($urandom_range(0, 7))
      0: r = raw_for_temp(temp_min) + d - 1;
      1: r = raw_for_temp(temp_max) + d - 1;
      2: r = ($urandom_range(0, 1) == 1) ? 65535 : 0;
      default: r = $urandom_range(0, 65535);
    endcase
    if (r < 0) begin
      r = 0;
    end
    if (r > 65535) begin
      r = 65535;
    end
    return r[15:0];
  endfunction

  // Mostly well-formed frames with random content, the rest loose noise.
  task automatic push_random(input int count);
    int          pushed;
    int          len;
    logic [15:0] hw;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 9) < 8) begin
        hw = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000)
                                         : 16'($urandom);
        push_frame(pick_temp_word(), hw, $urandom_range(0, 9) == 0,
                   $urandom_range(0, 9) == 0, $urandom_range(0, 3) != 0);
        pushed += 6;
      end else begin
        len = $urandom_range(1, 7);
        for (int i = 0; i < len; i++) begin
          push_byte(8'($urandom), $urandom_range(0, 5) == 0);
        end
        pushed += len;
      end
    end
  endtask

  function automatic centi_t rand_centi();
    int v;
    v = $urandom_range(0, 17500);
    return centi_t'(v - 4500);
  endfunction

  // Blocks until every byte is sent and every frame has come out. The check
  // runs mid-cycle so that the edge's updates have all settled.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (byte_queue.size() != 0 || rx.valid || expected_frames.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_limit(input cfg_index_t idx, input centi_t value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TEMP_MIN) begin
      temp_min = value;
    end else begin
      temp_max = value;
    end
  endtask

  task automatic run_phase(input centi_t lo, input centi_t hi, input int count);
    write_limit(CFG_TEMP_MIN, lo);
    write_limit(CFG_TEMP_MAX, hi);
    push_random(count);
    wait_idle();
  endtask

  // Main sequence: reset, directed frames, then random phases per limit pair.
  initial begin
    centi_t lo;
    centi_t hi;
    centi_t swap;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_TEMP_MIN;
    cfg_data = '0;
    temp_min = TEMP_MIN_RESET;
    temp_max = TEMP_MAX_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: coldest and hottest words, a wrap with no frame start,
    // a bad CRC on each word, and a partial frame cut off by a new start.
    push_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1);
    push_frame(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    push_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
    push_byte(8'hA5, 1'b1);
    push_frame(16'h8000, 16'h5A5A, 1'b0, 1'b1, 1'b1);
    push_random(250);
    wait_idle();

    // Widest window, then an inverted one where every frame fails.
    run_phase(-15'sd4500, 15'sd13000, 260);
    run_phase(15'sd13000, -15'sd4500, 260);
    for (int p = 0; p < 2; p++) begin
      lo = rand_centi();
      hi = rand_centi();
      if (lo > hi) begin
        swap = lo;
        lo = hi;
        hi = swap;
      end
      run_phase(lo, hi, 260);
    end
    lo = rand_centi();
    run_phase(lo, lo, 260);
    run_phase(TEMP_MIN_RESET, TEMP_MAX_RESET, 260);

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/htfc_pkg.sv
rtl/htfc_byte_if.sv
rtl/htfc_result_if.sv
rtl/htfc_front.sv
rtl/htfc_queue.sv
rtl/htfc_back.sv
rtl/humidity_temp_frame_checker.sv
rtl/htfc_checker.sv
tb/testbench.sv
